@@ rtl/motor_fault_monitor_assert.svh @@
// assertion macros for the motor fault monitor checker
`ifndef MOTOR_FAULT_MONITOR_ASSERT_SVH
`define MOTOR_FAULT_MONITOR_ASSERT_SVH

// same-cycle implication
`define MFM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfm assertion failed");

// next-cycle implication
`define MFM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfm assertion failed");

`endif

@@ rtl/mfm_pkg.sv @@
// shared types and constants of the motor fault monitor
package mfm_pkg;

   localparam int CURRENT_WIDTH_DEF = 16;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 23;

   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_UNDER = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUS_OVER  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMP      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIAG_AVG  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS      = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARN      = 3'd7;

   localparam int F_GATE  = 0;
   localparam int F_UV    = 1;
   localparam int F_OV    = 2;
   localparam int F_OC    = 3;
   localparam int F_TEMP  = 4;
   localparam int F_SPEED = 5;
   localparam int F_LOSS  = 6;
   localparam int F_IMB   = 7;

   typedef enum logic [1:0] {
      OP_SAMPLE     = 2'd0,
      OP_CLR_STATUS = 2'd1,
      OP_CLR_ALL    = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] mask;
      logic [7:0] raise;
   } cmd_type;

endpackage

@@ rtl/mfm_front.sv @@
// front end: config registers and three-stage sample classification pipeline
module mfm_front #(
   parameter int CURRENT_WIDTH = mfm_pkg::CURRENT_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [1:0]                         req_opcode,
   input  logic [7:0]                         req_clear_mask,
   input  logic                               req_gate_fault,
   input  logic [15:0]                        req_bus_volts,
   input  logic signed [CURRENT_WIDTH-1:0]    req_phase_a,
   input  logic signed [CURRENT_WIDTH-1:0]    req_phase_b,
   input  logic signed [CURRENT_WIDTH-1:0]    req_phase_c,
   input  logic signed [15:0]                 req_motor_temp,
   input  logic signed [23:0]                 req_rotor_speed,
   input  logic                               csr_write_en,
   input  logic [mfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                               cmd_push,
   output mfm_pkg::cmd_type                   cmd_data,
   input  logic                               cmd_full
);

   localparam int W  = CURRENT_WIDTH;
   localparam int SW = W + 2;
   localparam int LW = W + 10;
   localparam int PW = W + 18;
   localparam int AW = (SW > 17) ? SW : 17;

   logic [15:0] bus_under_ff, bus_over_ff, loss_ff, warn_ff;
   logic [14:0] current_ff, temp_ff, diag_ff;
   logic [22:0] speed_ff;

   logic                 f1_v_ff, f2_v_ff, f3_v_ff;
   logic                 f1_adv, f2_adv, f3_adv;

   mfm_pkg::op_type      f1_op_ff, f2_op_ff, f3_op_ff;
   logic [7:0]           f1_mask_ff, f2_mask_ff, f3_mask_ff;
   logic [5:0]           f1_raise_ff, f1_raise_in;
   logic [W-1:0]         f1_ma_ff, f1_mb_ff, f1_mc_ff;
   logic [W-1:0]         ma_in, mb_in, mc_in;
   logic [23:0]          spd_mag;

   logic [5:0]           f2_raise_ff, f2_raise_in, f3_raise_ff;
   logic                 oc_hit;
   logic [W-1:0]         f2_diff_ff, mx, mn;
   logic [SW-1:0]        f2_sum_ff, sum_in;
   logic                 f2_diag_ff, f3_diag_ff, diag_in;

   logic [LW-1:0]        f3_lhs_ff;
   logic [PW-1:0]        f3_lossp_ff, f3_warnp_ff;
   logic [PW-1:0]        lhs_ext;
   logic                 loss_hit, imb_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_under_ff <= '0;
         bus_over_ff  <= '0;
         current_ff   <= '0;
         temp_ff      <= '0;
         speed_ff     <= '0;
         diag_ff      <= '0;
         loss_ff      <= '0;
         warn_ff      <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            mfm_pkg::CSR_BUS_UNDER: bus_under_ff <= csr_wdata[15:0];
            mfm_pkg::CSR_BUS_OVER:  bus_over_ff  <= csr_wdata[15:0];
            mfm_pkg::CSR_CURRENT:   current_ff   <= csr_wdata[14:0];
            mfm_pkg::CSR_TEMP:      temp_ff      <= csr_wdata[14:0];
            mfm_pkg::CSR_SPEED:     speed_ff     <= csr_wdata[22:0];
            mfm_pkg::CSR_DIAG_AVG:  diag_ff      <= csr_wdata[14:0];
            mfm_pkg::CSR_LOSS:      loss_ff      <= csr_wdata[15:0];
            mfm_pkg::CSR_WARN:      warn_ff      <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign f3_adv   = !f3_v_ff || !cmd_full;
   assign f2_adv   = !f2_v_ff || f3_adv;
   assign f1_adv   = !f1_v_ff || f2_adv;
   assign req_full = !f1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
         f3_v_ff <= 1'b0;
      end else begin
         if (f1_adv) f1_v_ff <= req_push;
         if (f2_adv) f2_v_ff <= f1_v_ff;
         if (f3_adv) f3_v_ff <= f2_v_ff;
      end
   end

   // stage 1: magnitudes and plain threshold checks
   always_comb begin
      ma_in   = req_phase_a[W-1] ? (~req_phase_a + 1'b1) : req_phase_a;
      mb_in   = req_phase_b[W-1] ? (~req_phase_b + 1'b1) : req_phase_b;
      mc_in   = req_phase_c[W-1] ? (~req_phase_c + 1'b1) : req_phase_c;
      spd_mag = req_rotor_speed[23] ? (~req_rotor_speed + 1'b1) : req_rotor_speed;
      f1_raise_in = '0;
      f1_raise_in[mfm_pkg::F_GATE] = req_gate_fault;
      f1_raise_in[mfm_pkg::F_UV]   = (bus_under_ff != '0) && (req_bus_volts != '0) &&
                                     (req_bus_volts < bus_under_ff);
      f1_raise_in[mfm_pkg::F_OV]   = (bus_over_ff != '0) && (req_bus_volts > bus_over_ff);
      f1_raise_in[mfm_pkg::F_TEMP] = (temp_ff != '0) && !req_motor_temp[15] &&
                                     (req_motor_temp[14:0] > temp_ff);
      f1_raise_in[mfm_pkg::F_SPEED] = (speed_ff != '0) && (spd_mag > {1'b0, speed_ff});
   end

   always_ff @(posedge clock) begin
      if (f1_adv) begin
         f1_op_ff    <= mfm_pkg::op_type'(req_opcode);
         f1_mask_ff  <= req_clear_mask;
         f1_raise_ff <= f1_raise_in;
         f1_ma_ff    <= ma_in;
         f1_mb_ff    <= mb_in;
         f1_mc_ff    <= mc_in;
      end
   end

   // stage 2: max, min, sum, overcurrent and mean gate
   always_comb begin
      mx = f1_ma_ff;
      mn = f1_ma_ff;
      if (f1_mb_ff > mx) mx = f1_mb_ff;
      if (f1_mc_ff > mx) mx = f1_mc_ff;
      if (f1_mb_ff < mn) mn = f1_mb_ff;
      if (f1_mc_ff < mn) mn = f1_mc_ff;
      sum_in  = SW'(f1_ma_ff) + SW'(f1_mb_ff) + SW'(f1_mc_ff);
      diag_in = (diag_ff != '0) && ((loss_ff != '0) || (warn_ff != '0)) &&
                (AW'(sum_in) > (AW'(diag_ff) + AW'({diag_ff, 1'b0})));
      oc_hit  = (current_ff != '0) && (AW'(current_ff) < AW'(mx));
      f2_raise_in = f1_raise_ff;
      f2_raise_in[mfm_pkg::F_OC] = oc_hit;
   end

   always_ff @(posedge clock) begin
      if (f2_adv) begin
         f2_op_ff    <= f1_op_ff;
         f2_mask_ff  <= f1_mask_ff;
         f2_raise_ff <= f2_raise_in;
         f2_diff_ff  <= mx - mn;
         f2_sum_ff   <= sum_in;
         f2_diag_ff  <= diag_in;
      end
   end

   // stage 3: ratio products
   always_ff @(posedge clock) begin
      if (f3_adv) begin
         f3_op_ff    <= f2_op_ff;
         f3_mask_ff  <= f2_mask_ff;
         f3_raise_ff <= f2_raise_ff;
         f3_diag_ff  <= f2_diag_ff;
         f3_lhs_ff   <= (LW'(f2_diff_ff) << 9) + (LW'(f2_diff_ff) << 8);
         f3_lossp_ff <= PW'(loss_ff) * PW'(f2_sum_ff);
         f3_warnp_ff <= PW'(warn_ff) * PW'(f2_sum_ff);
      end
   end

   always_comb begin
      lhs_ext  = PW'(f3_lhs_ff);
      loss_hit = f3_diag_ff && (loss_ff != '0) && (lhs_ext > f3_lossp_ff);
      imb_hit  = f3_diag_ff && !loss_hit && (warn_ff != '0) && (lhs_ext > f3_warnp_ff);
      cmd_push = f3_v_ff && !cmd_full;
      cmd_data.op    = f3_op_ff;
      cmd_data.mask  = f3_mask_ff;
      cmd_data.raise = {imb_hit, loss_hit, f3_raise_ff};
   end

endmodule

@@ rtl/mfm_queue.sv @@
// small command queue between front and back
module mfm_queue #(
   parameter int DEPTH = mfm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mfm_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output mfm_pkg::cmd_type pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   mfm_pkg::cmd_type  mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (do_pop)
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         if (do_push && !do_pop)
            count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule

@@ rtl/mfm_back.sv @@
// back end: fault state update and result register
module mfm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_empty,
   input  mfm_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_fault_status,
   output logic [7:0]       rsp_fault_latched,
   output logic             rsp_latched_event
);

   logic [7:0] status_ff, status_in;
   logic [7:0] latched_ff, latched_in;
   logic       event_in;
   logic       rsp_v_ff;
   logic [7:0] rsp_status_ff, rsp_latched_ff;
   logic       rsp_event_ff;

   assign cmd_pop = !cmd_empty && (!rsp_v_ff || rsp_pop);

   always_comb begin
      status_in  = status_ff;
      latched_in = latched_ff;
      event_in   = 1'b0;
      unique case (cmd_data.op)
         mfm_pkg::OP_SAMPLE: begin
            status_in  = cmd_data.raise;
            latched_in = latched_ff | cmd_data.raise;
            event_in   = (latched_in != '0);
         end
         mfm_pkg::OP_CLR_STATUS: begin
            status_in = status_ff & ~cmd_data.mask;
         end
         mfm_pkg::OP_CLR_ALL: begin
            status_in  = status_ff & ~cmd_data.mask;
            latched_in = latched_ff & ~cmd_data.mask;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff  <= '0;
         latched_ff <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         if (cmd_pop) begin
            status_ff  <= status_in;
            latched_ff <= latched_in;
            rsp_v_ff   <= 1'b1;
         end else if (rsp_pop) begin
            rsp_v_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         rsp_status_ff  <= status_in;
         rsp_latched_ff <= latched_in;
         rsp_event_ff   <= event_in;
      end
   end

   assign rsp_empty         = !rsp_v_ff;
   assign rsp_fault_status  = rsp_status_ff;
   assign rsp_fault_latched = rsp_latched_ff;
   assign rsp_latched_event = rsp_event_ff;

endmodule

@@ rtl/motor_fault_monitor.sv @@
// motor fault monitor top level
//
//   channel   ports   handshake                    moves
//   request   req_*   push / full                  one sample or clear word
//   response  rsp_*   empty / pop                  one fault word per request
//   config    csr_*   csr_write_en, no wait        one threshold register
//
// one word per cycle sustained while the response side keeps popping; a request reaches
// the response ports through the three front stages, the command queue and the result register
// synchronous active-high reset clears thresholds, fault bits, the command queue and all valid flags
// a stalled response fills the command queue, then the front stages, then raises full
module motor_fault_monitor #(
   parameter int CURRENT_WIDTH = mfm_pkg::CURRENT_WIDTH_DEF,
   parameter int QUEUE_DEPTH   = mfm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [1:0]                         req_opcode,
   input  logic [7:0]                         req_clear_mask,
   input  logic                               req_gate_fault,
   input  logic [15:0]                        req_bus_volts,
   input  logic signed [CURRENT_WIDTH-1:0]    req_phase_a,
   input  logic signed [CURRENT_WIDTH-1:0]    req_phase_b,
   input  logic signed [CURRENT_WIDTH-1:0]    req_phase_c,
   input  logic signed [15:0]                 req_motor_temp,
   input  logic signed [23:0]                 req_rotor_speed,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [7:0]                         rsp_fault_status,
   output logic [7:0]                         rsp_fault_latched,
   output logic                               rsp_latched_event,
   input  logic                               csr_write_en,
   input  logic [mfm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic             q_push, q_full, q_pop, q_empty;
   mfm_pkg::cmd_type q_wdata, q_rdata;

   mfm_front #(
      .CURRENT_WIDTH (CURRENT_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_clear_mask  (req_clear_mask),
      .req_gate_fault  (req_gate_fault),
      .req_bus_volts   (req_bus_volts),
      .req_phase_a     (req_phase_a),
      .req_phase_b     (req_phase_b),
      .req_phase_c     (req_phase_c),
      .req_motor_temp  (req_motor_temp),
      .req_rotor_speed (req_rotor_speed),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .cmd_push        (q_push),
      .cmd_data        (q_wdata),
      .cmd_full        (q_full)
   );

   mfm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   mfm_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (q_empty),
      .cmd_data          (q_rdata),
      .cmd_pop           (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_fault_status  (rsp_fault_status),
      .rsp_fault_latched (rsp_fault_latched),
      .rsp_latched_event (rsp_latched_event)
   );

endmodule

@@ rtl/mfm_checker.sv @@
// port checker for the motor fault monitor and its bind
`include "motor_fault_monitor_assert.svh"

module mfm_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_fault_status,
   input logic [7:0] rsp_fault_latched,
   input logic       rsp_latched_event
);

   `MFM_ASSERT_IMP(a_event_has_latch, clock, reset, !rsp_empty && rsp_latched_event, rsp_fault_latched != 8'd0)
   `MFM_ASSERT_IMP(a_status_in_latch, clock, reset, !rsp_empty, (rsp_fault_status & ~rsp_fault_latched) == 8'd0)
   `MFM_ASSERT_IMP(a_full_needs_rsp, clock, reset, req_full, !rsp_empty)
   `MFM_ASSERT_NXT(a_rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_fault_status) && $stable(rsp_fault_latched) && $stable(rsp_latched_event))

endmodule

bind motor_fault_monitor mfm_checker u_mfm_checker (.*);

@@ tb/motor_fault_monitor_tb.sv @@
// self-checking testbench for the motor fault monitor: random and directed fault words
`timescale 1ns / 1ps

typedef struct {
   logic [1:0]         op;
   logic [7:0]         mask;
   logic               gate;
   logic [15:0]        volts;
   logic signed [15:0] pa;
   logic signed [15:0] pb;
   logic signed [15:0] pc;
   logic signed [15:0] temp;
   logic signed [23:0] speed;
} sample_word_type;

typedef struct {
   logic [7:0] status;
   logic [7:0] latched;
   logic       shutdown;
} fault_word_type;

typedef struct {
   logic [15:0] bus_under;
   logic [15:0] bus_over;
   logic [14:0] current_limit;
   logic [14:0] temp_max;
   logic [22:0] speed_max;
   logic [14:0] diag_min_avg;
   logic [15:0] loss_ratio;
   logic [15:0] warn_ratio;
} threshold_set_type;

class fault_tracker;
   threshold_set_type thr;
   logic [7:0]        status;
   logic [7:0]        latched;
   fault_word_type    expected_words[$];
   int                bad_words;

   function new();
      thr = '{default: '0};
      status = '0;
      latched = '0;
      bad_words = 0;
   endfunction

   function void write_register(logic [2:0] index, logic [22:0] value);
      case (index)
         mfm_pkg::CSR_BUS_UNDER: thr.bus_under = value[15:0];
         mfm_pkg::CSR_BUS_OVER:  thr.bus_over = value[15:0];
         mfm_pkg::CSR_CURRENT:   thr.current_limit = value[14:0];
         mfm_pkg::CSR_TEMP:      thr.temp_max = value[14:0];
         mfm_pkg::CSR_SPEED:     thr.speed_max = value[22:0];
         mfm_pkg::CSR_DIAG_AVG:  thr.diag_min_avg = value[14:0];
         mfm_pkg::CSR_LOSS:      thr.loss_ratio = value[15:0];
         mfm_pkg::CSR_WARN:      thr.warn_ratio = value[15:0];
         default: ;
      endcase
   endfunction

   function longint unsigned abs_of(logic [23:0] v, int w);
      longint unsigned u;
      u = 64'(v) & ((64'd1 << w) - 64'd1);
      if (((u >> (w - 1)) & 64'd1) != 0) return (64'd1 << w) - u;
      return u;
   endfunction

   function void take_request(sample_word_type w);
      longint unsigned ia, ib, ic, hi, lo, sum, spd, lhs;
      logic [7:0]      raised;
      fault_word_type  r;
      r.shutdown = 1'b0;
      raised = '0;
      case (w.op)
         mfm_pkg::OP_SAMPLE: begin
            ia = abs_of(24'(w.pa), 16);
            ib = abs_of(24'(w.pb), 16);
            ic = abs_of(24'(w.pc), 16);
            spd = abs_of(w.speed, 24);
            hi = ia;
            lo = ia;
            if (ib > hi) hi = ib;
            if (ic > hi) hi = ic;
            if (ib < lo) lo = ib;
            if (ic < lo) lo = ic;
            sum = ia + ib + ic;
            if (w.gate) raised[mfm_pkg::F_GATE] = 1'b1;
            if (thr.bus_under != 0 && w.volts != 0 && w.volts < thr.bus_under)
               raised[mfm_pkg::F_UV] = 1'b1;
            if (thr.bus_over != 0 && w.volts > thr.bus_over)
               raised[mfm_pkg::F_OV] = 1'b1;
            if (thr.current_limit != 0 && hi > thr.current_limit)
               raised[mfm_pkg::F_OC] = 1'b1;
            if (thr.temp_max != 0 && !w.temp[15] && w.temp[14:0] > thr.temp_max)
               raised[mfm_pkg::F_TEMP] = 1'b1;
            if (thr.speed_max != 0 && spd > thr.speed_max)
               raised[mfm_pkg::F_SPEED] = 1'b1;
            if (thr.diag_min_avg != 0 && (thr.loss_ratio != 0 || thr.warn_ratio != 0) &&
                sum > 64'd3 * thr.diag_min_avg) begin
               lhs = 64'd768 * (hi - lo);
               if (thr.loss_ratio != 0 && lhs > thr.loss_ratio * sum)
                  raised[mfm_pkg::F_LOSS] = 1'b1;
               else if (thr.warn_ratio != 0 && lhs > thr.warn_ratio * sum)
                  raised[mfm_pkg::F_IMB] = 1'b1;
            end
            status = raised;
            latched = latched | raised;
            r.shutdown = (latched != 0);
         end
         mfm_pkg::OP_CLR_STATUS: status = status & ~w.mask;
         mfm_pkg::OP_CLR_ALL: begin
            status = status & ~w.mask;
            latched = latched & ~w.mask;
         end
         default: ;
      endcase
      r.status = status;
      r.latched = latched;
      expected_words.push_back(r);
   endfunction

   function void check_word(fault_word_type got);
      fault_word_type want;
      if (expected_words.size() == 0) begin
         bad_words++;
         if (bad_words <= 10)
            $display("unexpected fault word: status %h latched %h event %b",
                     got.status, got.latched, got.shutdown);
         return;
      end
      want = expected_words.pop_front();
      if (got.status !== want.status || got.latched !== want.latched ||
          got.shutdown !== want.shutdown) begin
         bad_words++;
         if (bad_words <= 10)
            $display("fault word mismatch: status %h/%h latched %h/%h event %b/%b (exp/got)",
                     want.status, got.status, want.latched, got.latched,
                     want.shutdown, got.shutdown);
      end
   endfunction

   function int waiting();
      return expected_words.size();
   endfunction
endclass

module motor_fault_monitor_tb;

   localparam int         CYCLE_LIMIT = 400000;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_push = 1'b0;
   logic                             req_full;
   logic [1:0]                       req_opcode = '0;
   logic [7:0]                       req_clear_mask = '0;
   logic                             req_gate_fault = 1'b0;
   logic [15:0]                      req_bus_volts = '0;
   logic signed [15:0]               req_phase_a = '0;
   logic signed [15:0]               req_phase_b = '0;
   logic signed [15:0]               req_phase_c = '0;
   logic signed [15:0]               req_motor_temp = '0;
   logic signed [23:0]               req_rotor_speed = '0;
   logic                             rsp_empty;
   logic                             rsp_pop = 1'b0;
   logic [7:0]                       rsp_fault_status;
   logic [7:0]                       rsp_fault_latched;
   logic                             rsp_latched_event;
   logic                             csr_write_en = 1'b0;
   logic [mfm_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [mfm_pkg::CSR_DATA_W-1:0]   csr_wdata = '0;

   fault_tracker tracker;
   bit           tx_idle = 1'b0;
   bit           rx_idle = 1'b0;
   int           hold_off = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   motor_fault_monitor dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_clear_mask    (req_clear_mask),
      .req_gate_fault    (req_gate_fault),
      .req_bus_volts     (req_bus_volts),
      .req_phase_a       (req_phase_a),
      .req_phase_b       (req_phase_b),
      .req_phase_c       (req_phase_c),
      .req_motor_temp    (req_motor_temp),
      .req_rotor_speed   (req_rotor_speed),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_fault_status  (rsp_fault_status),
      .rsp_fault_latched (rsp_fault_latched),
      .rsp_latched_event (rsp_latched_event),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   function automatic sample_word_type sample_of(logic gate, logic [15:0] volts,
                                                 logic signed [15:0] a, logic signed [15:0] b,
                                                 logic signed [15:0] c, logic signed [15:0] temp,
                                                 logic signed [23:0] speed);
      sample_word_type w;
      w.op = mfm_pkg::OP_SAMPLE;
      w.mask = 8'($urandom);
      w.gate = gate;
      w.volts = volts;
      w.pa = a;
      w.pb = b;
      w.pc = c;
      w.temp = temp;
      w.speed = speed;
      return w;
   endfunction

   function automatic sample_word_type clear_of(logic [1:0] op, logic [7:0] mask);
      sample_word_type w;
      w = sample_of(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), 16'($urandom), 24'($urandom));
      w.op = op;
      w.mask = mask;
      return w;
   endfunction

   function automatic threshold_set_type thresholds_of(int unsigned under, int unsigned over,
                                                       int unsigned cur, int unsigned temp,
                                                       int unsigned spd, int unsigned diag,
                                                       int unsigned loss, int unsigned warn);
      threshold_set_type t;
      t.bus_under = 16'(under);
      t.bus_over = 16'(over);
      t.current_limit = 15'(cur);
      t.temp_max = 15'(temp);
      t.speed_max = 23'(spd);
      t.diag_min_avg = 15'(diag);
      t.loss_ratio = 16'(loss);
      t.warn_ratio = 16'(warn);
      return t;
   endfunction

   function automatic int unsigned pick_limit(int unsigned top, int unsigned useful);
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return 0;
      if (r == 1) return top;
      return $urandom_range(1, useful);
   endfunction

   function automatic logic signed [15:0] signed_current(int unsigned m);
      logic signed [15:0] v;
      v = 16'(m);
      return $urandom_range(0, 1) ? -v : v;
   endfunction

   function automatic sample_word_type random_word();
      sample_word_type w;
      int unsigned     r, base;
      logic signed [15:0] cur[3];
      r = $urandom_range(0, 99);
      w = clear_of(OP_UNUSED, 8'($urandom));
      w.gate = ($urandom_range(0, 4) == 0);
      if (r < 70) w.op = mfm_pkg::OP_SAMPLE;
      else if (r < 84) w.op = mfm_pkg::OP_CLR_STATUS;
      else if (r < 97) w.op = mfm_pkg::OP_CLR_ALL;
      base = $urandom_range(0, 20000);
      case ($urandom_range(0, 3))
         0: for (int i = 0; i < 3; i++) cur[i] = 16'($urandom);
         1: for (int i = 0; i < 3; i++) cur[i] = signed_current(base + $urandom_range(0, 2000));
         2: begin
            for (int i = 0; i < 3; i++) cur[i] = signed_current(base + $urandom_range(0, 500));
            cur[$urandom_range(0, 2)] = signed_current($urandom_range(0, 200));
         end
         default: for (int i = 0; i < 3; i++) cur[i] = signed_current($urandom_range(0, 3000));
      endcase
      w.pa = cur[0];
      w.pb = cur[1];
      w.pc = cur[2];
      return w;
   endfunction

   task automatic send_word(sample_word_type w);
      int gap;
      gap = tx_idle ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= w.op;
      req_clear_mask <= w.mask;
      req_gate_fault <= w.gate;
      req_bus_volts <= w.volts;
      req_phase_a <= w.pa;
      req_phase_b <= w.pb;
      req_phase_c <= w.pc;
      req_motor_temp <= w.temp;
      req_rotor_speed <= w.speed;
      do @(posedge clock); while (req_full);
      tracker.take_request(w);
      @(negedge clock);
   endtask

   task automatic write_threshold(logic [mfm_pkg::CSR_INDEX_W-1:0] index,
                                  logic [mfm_pkg::CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_register(index, value);
      @(negedge clock);
   endtask

   task automatic load_thresholds(threshold_set_type t);
      write_threshold(mfm_pkg::CSR_BUS_UNDER, 23'(t.bus_under));
      write_threshold(mfm_pkg::CSR_BUS_OVER, 23'(t.bus_over));
      write_threshold(mfm_pkg::CSR_CURRENT, 23'(t.current_limit));
      write_threshold(mfm_pkg::CSR_TEMP, 23'(t.temp_max));
      write_threshold(mfm_pkg::CSR_SPEED, t.speed_max);
      write_threshold(mfm_pkg::CSR_DIAG_AVG, 23'(t.diag_min_avg));
      write_threshold(mfm_pkg::CSR_LOSS, 23'(t.loss_ratio));
      write_threshold(mfm_pkg::CSR_WARN, 23'(t.warn_ratio));
      csr_write_en <= 1'b0;
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (tracker.waiting() != 0) @(negedge clock);
   endtask

   initial begin : response_side
      int             stall;
      fault_word_type got;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            stall = hold_off;
            hold_off = 0;
         end else begin
            stall = rx_idle ? $urandom_range(0, 12) : 0;
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         got.status = rsp_fault_status;
         got.latched = rsp_fault_latched;
         got.shutdown = rsp_latched_event;
         tracker.check_word(got);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("motor_fault_monitor_tb failed");
      $finish;
   end

   initial begin : request_side
      threshold_set_type thr;
      tracker = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all checks disabled after reset: only the gate fault can latch
      send_word(sample_of(1'b1, 16'hFFFF, -16'sd32768, 16'sd32767, 16'sd0,
                          16'sd32767, -24'sd8388608));
      send_word(clear_of(mfm_pkg::OP_CLR_STATUS, 8'hFF));
      send_word(clear_of(OP_UNUSED, 8'hFF));
      send_word(clear_of(mfm_pkg::OP_CLR_ALL, 8'hFF));
      send_word(sample_of(1'b0, 16'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 24'sd0));
      settle();

      load_thresholds(thresholds_of(4800, 6000, 20000, 1000, 25600, 500, 512, 128));
      send_word(sample_of(1'b0, 16'd0, 16'sd100, 16'sd100, 16'sd100, 16'sd0, 24'sd0));
      send_word(sample_of(1'b0, 16'd1, 16'sd100, 16'sd100, 16'sd100, 16'sd0, 24'sd0));
      send_word(sample_of(1'b0, 16'd6001, 16'sd0, 16'sd0, 16'sd0, 16'sd1000, 24'sd25600));
      send_word(sample_of(1'b0, 16'd6000, -16'sd20001, 16'sd20000, -16'sd20000,
                          16'sd1001, -24'sd25601));
      send_word(sample_of(1'b0, 16'd5000, 16'sd3000, 16'sd0, 16'sd0,
                          -16'sd32768, 24'sd0));
      send_word(sample_of(1'b0, 16'd5000, 16'sd3000, -16'sd3000, 16'sd0, 16'sd0, 24'sd0));
      send_word(sample_of(1'b0, 16'd5000, 16'sd1000, -16'sd1000, 16'sd1000, 16'sd0, 24'sd0));
      send_word(sample_of(1'b1, 16'd5000, 16'sd400, 16'sd0, 16'sd0, 16'sd0, 24'sd0));
      send_word(clear_of(mfm_pkg::OP_CLR_STATUS, 8'h0F));
      send_word(clear_of(mfm_pkg::OP_CLR_ALL, 8'h00));
      send_word(clear_of(mfm_pkg::OP_CLR_ALL, 8'hF0));
      send_word(clear_of(mfm_pkg::OP_CLR_ALL, 8'hFF));
      settle();

      // both ratios zero: imbalance check skipped
      load_thresholds(thresholds_of(65535, 65535, 32767, 32767, 8388607, 1, 0, 0));
      send_word(sample_of(1'b0, 16'd65534, -16'sd32768, 16'sd0, 16'sd0,
                          16'sd32767, -24'sd8388608));
      send_word(sample_of(1'b0, 16'd65535, 16'sd5000, 16'sd0, 16'sd0, 16'sd0, 24'sd8388607));
      settle();

      load_thresholds(thresholds_of(1, 1, 1, 1, 1, 1, 1, 1));
      send_word(sample_of(1'b0, 16'd1, 16'sd2, 16'sd0, -16'sd1, 16'sd2, 24'sd2));
      send_word(sample_of(1'b0, 16'd2, -16'sd32768, -16'sd32768, -16'sd32768,
                          16'sd32767, 24'sd8388607));
      send_word(sample_of(1'b0, 16'd1, 16'sd32767, 16'sd0, 16'sd1, 16'sd0, 24'sd0));
      settle();

      load_thresholds(thresholds_of(65535, 65535, 32767, 32767, 8388607, 32767, 65535, 65535));
      send_word(sample_of(1'b0, 16'd0, -16'sd32768, -16'sd32768, -16'sd32768,
                          16'sd0, 24'sd0));
      send_word(sample_of(1'b0, 16'd0, -16'sd32768, -16'sd32768, 16'sd32767,
                          16'sd0, 24'sd0));
      settle();

      for (int phase = 0; phase < 13; phase++) begin
         settle();
         if (phase == 0)
            thr = thresholds_of(0, 0, 0, 0, 0, 0, 0, 0);
         else
            thr = thresholds_of(pick_limit(65535, 40000), pick_limit(65535, 65535),
                                pick_limit(32767, 32767), pick_limit(32767, 32767),
                                pick_limit(8388607, 8388607), pick_limit(32767, 12000),
                                pick_limit(65535, 900), pick_limit(65535, 600));
         load_thresholds(thr);
         tx_idle = phase[0];
         rx_idle = phase[1];
         if (phase == 3 || phase == 9) begin
            tx_idle = 1'b0;
            hold_off = 80;
         end
         for (int k = 0; k < 100; k++) send_word(random_word());
      end
      settle();
      repeat (8) @(posedge clock);

      if (tracker.bad_words == 0)
         $display("motor_fault_monitor_tb passed");
      else
         $display("motor_fault_monitor_tb failed");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl
rtl/mfm_pkg.sv
rtl/mfm_front.sv
rtl/mfm_queue.sv
rtl/mfm_back.sv
rtl/motor_fault_monitor.sv
rtl/mfm_checker.sv
tb/motor_fault_monitor_tb.sv
